// ===== src/itrd_pkg.sv =====
package itrd_pkg;

	// Default build parameters
	localparam int MAX_RADIX_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field and register widths
	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 5;
	localparam int ALPHA_W  = 64;
	localparam int CFG_IDX_W = 2;

	// Dividend bits consumed by the divider step in one cycle
	localparam int STEP_BITS = 8;

	// Symbol emitted ahead of a negative value
	localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'h2D;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

endpackage

// ===== src/itrd_div_step.sv =====
module itrd_div_step #(
	parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEF,
	localparam int DIGIT_W = $clog2(MAX_RADIX),
	localparam int RAD_W = $clog2(MAX_RADIX + 1)
) (
	input  logic [DIGIT_W-1:0]             rem_in,
	input  logic [itrd_pkg::STEP_BITS-1:0] bits_in,
	input  logic [RAD_W-1:0]               radix,
	output logic [DIGIT_W-1:0]             rem_out,
	output logic [itrd_pkg::STEP_BITS-1:0] quot_bits
);

	localparam int T_W = DIGIT_W + 1;

	// Restoring division of one dividend slice by the radix, one bit per stage
	always_comb begin
		logic [T_W-1:0] t;
		logic [DIGIT_W-1:0] r;
		r = rem_in;
		quot_bits = '0;
		for (int i = itrd_pkg::STEP_BITS - 1; i >= 0; i--) begin
			t = {r, bits_in[i]};
			if (t >= T_W'(radix)) begin
				quot_bits[i] = 1'b1;
				t = t - T_W'(radix);
			end
			r = t[DIGIT_W-1:0];
		end
		rem_out = r;
	end

endmodule

// ===== src/integer_to_radix_digits_core.sv =====
// Signed integer to text in a programmable radix (2 to 16).
//
// Channels: one value per beat on the s_ side (s_tdata = value, 32 bits,
// low VALUE_BITS bits used). Characters leave one per beat on the m_ side,
// most significant digit first, with a leading minus sign for negative
// values; m_tlast marks the final character of each value's text.
// The cfg port writes radix (index 0), alphabet_low (1) and alphabet_high
// (2); write only while the block is idle.
//
// Sequence: after a value is accepted, each digit is computed in the shared
// divider (8 quotient bits per cycle), one dividend slice at a time; the
// characters then leave one per beat, pausing while the receiver stalls.
// s_tready is high only while the sequencer is idle; the final character
// may still sit in the output register when the next value is taken.
//
// Reset clears the sequencer and output valid, sets radix to 10 and the
// alphabet to zero bytes. A stalled receiver holds the current character and
// pauses the character sequencer.
module integer_to_radix_digits_core #(
	parameter int MAX_RADIX  = itrd_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [itrd_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [itrd_pkg::CHAR_W-1:0]       m_tdata,   // [7:0] character
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itrd_pkg::ALPHA_W-1:0]      cfg_wdata
);

	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int RAD_W   = $clog2(MAX_RADIX + 1);
	localparam int STEPS   = (VALUE_BITS + itrd_pkg::STEP_BITS - 1) / itrd_pkg::STEP_BITS;
	localparam int PAD_W   = STEPS * itrd_pkg::STEP_BITS;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IDX_W   = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;

	logic [itrd_pkg::RADIX_W-1:0] radix_q;
	logic [itrd_pkg::ALPHA_W-1:0] alpha_low_q;
	logic [itrd_pkg::ALPHA_W-1:0] alpha_high_q;

	logic [PAD_W-1:0]   work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [IDX_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic               minus_q;
	logic [DIGIT_W-1:0] digits_q [VALUE_BITS];

	logic                        m_tvalid_q;
	logic [itrd_pkg::CHAR_W-1:0] m_tdata_q;
	logic                        m_tlast_q;

	logic [VALUE_BITS-1:0]        raw;
	logic                         neg;
	logic [VALUE_BITS-1:0]        mag;
	logic [RAD_W-1:0]             radix_eff;
	logic [DIGIT_W-1:0]           rem_next;
	logic [itrd_pkg::STEP_BITS-1:0] quot_bits;
	logic [PAD_W-1:0]             work_next;
	logic                         last_step;
	logic                         div_done;
	logic                         out_free;
	logic                         load_out;
	logic [2*itrd_pkg::ALPHA_W-1:0] alphabet;
	logic [itrd_pkg::CHAR_W-1:0]  symbol;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= itrd_pkg::RADIX_RESET;
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				itrd_pkg::CFG_RADIX:      radix_q <= cfg_wdata[itrd_pkg::RADIX_W-1:0];
				itrd_pkg::CFG_ALPHA_LOW:  alpha_low_q <= cfg_wdata;
				itrd_pkg::CFG_ALPHA_HIGH: alpha_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the radix into the supported range
	always_comb begin
		if (radix_q < itrd_pkg::RADIX_W'(2)) begin
			radix_eff = RAD_W'(2);
		end else if (radix_q > itrd_pkg::RADIX_W'(MAX_RADIX)) begin
			radix_eff = RAD_W'(MAX_RADIX);
		end else begin
			radix_eff = RAD_W'(radix_q);
		end
	end

	// Magnitude of the incoming value; the most negative value wraps to 2^(N-1)
	assign raw = s_tdata[VALUE_BITS-1:0];
	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? (~raw + 1'b1) : raw;

	// Shared divider step: one dividend slice per cycle
	itrd_div_step #(
		.MAX_RADIX(MAX_RADIX)
	) u_div (
		.rem_in   (rem_q),
		.bits_in  (work_q[PAD_W-1 -: itrd_pkg::STEP_BITS]),
		.radix    (radix_eff),
		.rem_out  (rem_next),
		.quot_bits(quot_bits)
	);

	// Shift the consumed slice out, quotient bits in
	assign work_next = PAD_W'({work_q, quot_bits});
	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign div_done  = (work_next == '0) || (count_q == IDX_W'(VALUE_BITS - 1));

	// Map the current digit through the alphabet
	assign alphabet = {alpha_high_q, alpha_low_q};
	assign symbol   = alphabet[{4'(digits_q[idx_q]), 3'b000} +: itrd_pkg::CHAR_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == ST_EMIT) && out_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			minus_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						count_q <= '0;
						minus_q <= neg;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						step_q <= '0;
						if (div_done) begin
							idx_q   <= count_q;
							state_q <= ST_EMIT;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (minus_q) begin
							minus_q <= 1'b0;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Dividend, remainder and digit store
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			work_q <= PAD_W'(mag);
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			work_q <= work_next;
			if (last_step) begin
				digits_q[count_q] <= rem_next;
				rem_q <= '0;
			end else begin
				rem_q <= rem_next;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (minus_q) begin
				m_tdata_q <= itrd_pkg::MINUS_SIGN;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= symbol;
				m_tlast_q <= (idx_q == '0);
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== src/itrd_checker.sv =====
module itrd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [itrd_pkg::CHAR_W-1:0] m_tdata,
	input logic                        m_tlast
);

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Go busy after taking a value
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a value was taken");

	// Stay busy while a text is only partly delivered
	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while a text is still being emitted");

	// Only the final character may wait when a new value enters
	a_accept_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tlast)
		else $error("new value taken while a non-final character waits");

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
